/* rtl/core/drdf_pkg.sv */
// ----------------------------------------------------------------------------
// drdf_pkg
// Shared types and constants of the dictionary record deframer: result kinds
// and the command that travels from the parser to the result sequencer.
// ----------------------------------------------------------------------------
package drdf_pkg;

    // default number of big-endian length bytes a header may announce
    localparam int MAX_LENGTH_BYTES_DEF = 4;

    // depth of the command queue between parser and sequencer
    localparam int QUEUE_DEPTH = 4;

    // result kinds
    typedef enum logic [2:0] {
        KIND_HEADWORD   = 3'd0,
        KIND_DEFINITION = 3'd1,
        KIND_POS_INDEX  = 3'd2,
        KIND_ALTERNATE  = 3'd3,
        KIND_OTHER      = 3'd4,
        KIND_BLOCK_END  = 3'd5,
        KIND_STREAM_END = 3'd6
    } t_kind;

    // block types and byte codes
    localparam logic [3:0] TYPE_STREAM_END = 4'h4;
    localparam logic [3:0] TYPE_ENTRY_A    = 4'h1;
    localparam logic [3:0] TYPE_ENTRY_B    = 4'ha;
    localparam logic [7:0] BYTE_LF         = 8'h0a;
    localparam logic [7:0] BYTE_MARK       = 8'h14;
    localparam logic [7:0] BYTE_POS        = 8'h02;
    localparam logic [7:0] BYTE_DIGIT0     = 8'h30;
    localparam logic [7:0] POS_INDEX_MAX   = 8'd10;

    // work for the sequencer caused by one input byte
    typedef struct packed {
        logic       item_valid;  // one result from the fields below
        logic       br;          // four definition results of a line-break tag
        logic       end_valid;   // block-end result after the others
        t_kind      item_kind;
        logic [7:0] value;
        logic [7:0] alt;
        logic [3:0] block_kind;
    } t_cmd;

endpackage

/* rtl/core/dictionary_record_deframer_unit.sv */
// ----------------------------------------------------------------------------
// dictionary_record_deframer_unit
// Deframes a decompressed dictionary byte stream into typed result beats.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue write port: drive i_data_byte with push high; the
//   byte is taken on a rising edge where full is low. Result side is a queue
//   read port: while empty is low the oldest result sits on o_kind, o_value,
//   o_block_kind, o_alternate_number and o_last; pop high takes it.
//   The parser takes one byte per cycle while full is low and writes at most
//   one command per byte into a four-entry queue. The sequencer turns each
//   command into one to five result beats, one beat per cycle while pop is
//   high (a line feed in a definition gives four beats, plus a block-end beat
//   if it closes the block). A byte's results pass through the queue and the
//   output register. Throughput: one byte per cycle while results are taken
//   at once and each byte gives at most one result; otherwise the sequencer's
//   one beat per cycle sets the rate, and full rises once the queue fills.
//   When the receiver holds pop low, the output register keeps its beat,
//   the queue fills and full stalls the sender; nothing is dropped.
//   Reset (synchronous, i_rst_n low) returns the parser to the header phase
//   and empties the queue and output register.
// ----------------------------------------------------------------------------
module dictionary_record_deframer_unit #(
    parameter int MAX_LENGTH_BYTES = drdf_pkg::MAX_LENGTH_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_data_byte,
    output logic       empty,
    input  logic       pop,
    output logic [2:0] o_kind,
    output logic [7:0] o_value,
    output logic [3:0] o_block_kind,
    output logic [7:0] o_alternate_number,
    output logic       o_last
);

    logic           v_accept;
    logic           v_cmd_valid;
    drdf_pkg::t_cmd v_cmd;
    drdf_pkg::t_cmd v_head;
    logic           v_head_valid;
    logic           v_head_pop;
    logic           v_full;

    // input beat handshake
    assign v_accept = push && !v_full;
    assign full     = v_full;

    drdf_front #(
        .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (v_accept),
        .i_data_byte (i_data_byte),
        .o_cmd_valid (v_cmd_valid),
        .o_cmd       (v_cmd)
    );

    drdf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (v_cmd_valid),
        .i_cmd        (v_cmd),
        .i_pop        (v_head_pop),
        .o_head       (v_head),
        .o_head_valid (v_head_valid),
        .o_full       (v_full)
    );

    drdf_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_head             (v_head),
        .i_head_valid       (v_head_valid),
        .o_head_pop         (v_head_pop),
        .i_pop              (pop),
        .o_empty            (empty),
        .o_kind             (o_kind),
        .o_value            (o_value),
        .o_block_kind       (o_block_kind),
        .o_alternate_number (o_alternate_number),
        .o_last             (o_last)
    );

endmodule

/* rtl/core/drdf_front.sv */
// ----------------------------------------------------------------------------
// drdf_front
// Block and field parser: consumes one stream byte per accepted beat, keeps
// the framing state and issues at most one command per byte.
// ----------------------------------------------------------------------------
module drdf_front #(
    parameter int MAX_LENGTH_BYTES = drdf_pkg::MAX_LENGTH_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_data_byte,
    output logic           o_cmd_valid,
    output drdf_pkg::t_cmd o_cmd
);

    localparam int PW = 8 * MAX_LENGTH_BYTES;

    typedef enum logic [3:0] {
        PH_HEADER, PH_LENGTH, PH_RAW, PH_HW_LEN, PH_HW, PH_DEF_HI, PH_DEF_LO,
        PH_DEF, PH_DEF_POS, PH_DEF_SKIP, PH_ALT_LEN, PH_ALT
    } t_phase;

    t_phase          r_phase, n_phase;
    logic [3:0]      r_type, n_type;
    logic [2:0]      r_len_left, n_len_left;
    logic [PW-1:0]   r_payload, n_payload;
    logic [15:0]     r_field, n_field;
    logic [7:0]      r_alt_cnt, n_alt_cnt;
    logic            r_marker, n_marker;
    drdf_pkg::t_cmd  v_cmd;

    // next-state and command decode for the byte on the input
    always_comb begin
        logic [3:0] v_hi;
        logic       v_eligible;
        logic       v_body;
        v_hi       = i_data_byte[7:4];
        v_eligible = (r_field >= 16'd3);
        v_body     = 1'b0;
        n_phase    = r_phase;
        n_type     = r_type;
        n_len_left = r_len_left;
        n_payload  = r_payload;
        n_field    = r_field;
        n_alt_cnt  = r_alt_cnt;
        n_marker   = r_marker;
        v_cmd      = '0;

        case (r_phase)
            PH_HEADER: begin
                n_type     = i_data_byte[3:0];
                n_marker   = 1'b0;
                n_alt_cnt  = 8'd0;
                n_field    = 16'd0;
                n_len_left = 3'd0;
                n_payload  = '0;
                if (i_data_byte[3:0] == drdf_pkg::TYPE_STREAM_END) begin
                    v_cmd.item_valid = 1'b1;
                    v_cmd.item_kind  = drdf_pkg::KIND_STREAM_END;
                end else if (v_hi < 4'd4) begin
                    if ((3'(v_hi[1:0]) + 3'd1) > 3'(MAX_LENGTH_BYTES)) begin
                        v_cmd.end_valid = 1'b1;
                    end else begin
                        n_len_left = 3'(v_hi[1:0]) + 3'd1;
                        n_phase    = PH_LENGTH;
                    end
                end else begin
                    n_payload = PW'(v_hi - 4'd4);
                    if (v_hi == 4'd4) begin
                        v_cmd.end_valid = 1'b1;
                    end else if (i_data_byte[3:0] == drdf_pkg::TYPE_ENTRY_A ||
                                 i_data_byte[3:0] == drdf_pkg::TYPE_ENTRY_B) begin
                        n_phase = PH_HW_LEN;
                    end else begin
                        n_phase = PH_RAW;
                    end
                end
            end
            PH_LENGTH: begin
                n_payload = PW'({r_payload, i_data_byte});
                if (r_len_left != 3'd0) begin
                    n_len_left = r_len_left - 3'd1;
                end
                if (n_len_left == 3'd0) begin
                    if (n_payload == '0) begin
                        v_cmd.end_valid = 1'b1;
                        n_phase         = PH_HEADER;
                    end else if (r_type == drdf_pkg::TYPE_ENTRY_A ||
                                 r_type == drdf_pkg::TYPE_ENTRY_B) begin
                        n_phase = PH_HW_LEN;
                    end else begin
                        n_phase = PH_RAW;
                    end
                end
            end
            PH_HW_LEN: begin
                v_body  = 1'b1;
                n_field = {8'd0, i_data_byte};
                n_phase = (i_data_byte != 8'd0) ? PH_HW : PH_DEF_HI;
            end
            PH_HW: begin
                v_body           = 1'b1;
                v_cmd.item_valid = 1'b1;
                v_cmd.item_kind  = drdf_pkg::KIND_HEADWORD;
                v_cmd.value      = i_data_byte;
                if (r_field != 16'd0) begin
                    n_field = r_field - 16'd1;
                end
                if (n_field == 16'd0) begin
                    n_phase = PH_DEF_HI;
                end
            end
            PH_DEF_HI: begin
                v_body  = 1'b1;
                n_field = {i_data_byte, 8'd0};
                n_phase = PH_DEF_LO;
            end
            PH_DEF_LO: begin
                v_body   = 1'b1;
                n_field  = r_field | {8'd0, i_data_byte};
                n_marker = 1'b0;
                n_phase  = (n_field != 16'd0) ? PH_DEF : PH_ALT_LEN;
            end
            PH_DEF: begin
                v_body = 1'b1;
                if (r_marker && i_data_byte == drdf_pkg::BYTE_POS) begin
                    // marker completed: next byte carries the index
                    n_marker = 1'b0;
                    if (r_field != 16'd0) begin
                        n_field = r_field - 16'd1;
                    end
                    n_phase = PH_DEF_POS;
                end else begin
                    n_marker = 1'b0;
                    if (i_data_byte == drdf_pkg::BYTE_LF) begin
                        v_cmd.br = 1'b1;
                    end else if (i_data_byte == drdf_pkg::BYTE_MARK) begin
                        n_marker = v_eligible;
                    end else begin
                        v_cmd.item_valid = 1'b1;
                        v_cmd.item_kind  = drdf_pkg::KIND_DEFINITION;
                        v_cmd.value      = i_data_byte;
                    end
                    if (r_field != 16'd0) begin
                        n_field = r_field - 16'd1;
                    end
                    if (n_field == 16'd0) begin
                        n_marker = 1'b0;
                        n_phase  = PH_ALT_LEN;
                    end
                end
            end
            PH_DEF_POS: begin
                v_body = 1'b1;
                if (i_data_byte >= drdf_pkg::BYTE_DIGIT0 &&
                    (i_data_byte - drdf_pkg::BYTE_DIGIT0) <= drdf_pkg::POS_INDEX_MAX) begin
                    v_cmd.item_valid = 1'b1;
                    v_cmd.item_kind  = drdf_pkg::KIND_POS_INDEX;
                    v_cmd.value      = i_data_byte - drdf_pkg::BYTE_DIGIT0;
                end
                if (r_field != 16'd0) begin
                    n_field = r_field - 16'd1;
                end
                n_phase = (n_field != 16'd0) ? PH_DEF_SKIP : PH_ALT_LEN;
            end
            PH_DEF_SKIP: begin
                v_body = 1'b1;
                if (r_field != 16'd0) begin
                    n_field = r_field - 16'd1;
                end
                if (n_field == 16'd0) begin
                    n_phase = PH_ALT_LEN;
                end
            end
            PH_ALT_LEN: begin
                v_body  = 1'b1;
                n_field = {8'd0, i_data_byte};
                if (r_alt_cnt != 8'hff) begin
                    n_alt_cnt = r_alt_cnt + 8'd1;
                end
                n_phase = (i_data_byte != 8'd0) ? PH_ALT : PH_ALT_LEN;
            end
            PH_ALT: begin
                v_body           = 1'b1;
                v_cmd.item_valid = 1'b1;
                v_cmd.item_kind  = drdf_pkg::KIND_ALTERNATE;
                v_cmd.value      = i_data_byte;
                v_cmd.alt        = r_alt_cnt;
                if (r_field != 16'd0) begin
                    n_field = r_field - 16'd1;
                end
                if (n_field == 16'd0) begin
                    n_phase = PH_ALT_LEN;
                end
            end
            PH_RAW: begin
                v_body           = 1'b1;
                v_cmd.item_valid = 1'b1;
                v_cmd.item_kind  = drdf_pkg::KIND_OTHER;
                v_cmd.value      = i_data_byte;
            end
            default: begin
                n_phase = PH_HEADER;
            end
        endcase

        // payload count runs down on every body byte
        if (v_body) begin
            if (r_payload != '0) begin
                n_payload = r_payload - PW'(1);
            end
            if (n_payload == '0) begin
                n_phase         = PH_HEADER;
                n_marker        = 1'b0;
                v_cmd.end_valid = 1'b1;
            end
        end

        v_cmd.block_kind = n_type;
    end

    assign o_cmd       = v_cmd;
    assign o_cmd_valid = i_accept && (v_cmd.item_valid || v_cmd.br || v_cmd.end_valid);

    // framing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_type     <= 4'd0;
            r_len_left <= 3'd0;
            r_payload  <= '0;
            r_field    <= 16'd0;
            r_alt_cnt  <= 8'd0;
            r_marker   <= 1'b0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_type     <= n_type;
            r_len_left <= n_len_left;
            r_payload  <= n_payload;
            r_field    <= n_field;
            r_alt_cnt  <= n_alt_cnt;
            r_marker   <= n_marker;
        end
    end

endmodule

/* rtl/core/drdf_queue.sv */
// ----------------------------------------------------------------------------
// drdf_queue
// Short command queue that decouples the parser from the result sequencer.
// ----------------------------------------------------------------------------
module drdf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  drdf_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output drdf_pkg::t_cmd o_head,
    output logic           o_head_valid,
    output logic           o_full
);

    localparam int DEPTH = drdf_pkg::QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    drdf_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [AW:0]    r_count;

    assign o_full       = (r_count == (AW+1)'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (AW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (AW+1)'(1);
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (AW+1)'(DEPTH))
        else $error("queue count above depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_head_valid))
        else $error("pop from empty queue");
    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> o_head_valid)
        else $error("queue empty after push");
`endif

endmodule

/* rtl/core/drdf_back.sv */
// ----------------------------------------------------------------------------
// drdf_back
// Result sequencer: expands each queued command into one to five result
// beats and holds the oldest result in the output register.
// ----------------------------------------------------------------------------
module drdf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  drdf_pkg::t_cmd i_head,
    input  logic           i_head_valid,
    output logic           o_head_pop,
    input  logic           i_pop,
    output logic           o_empty,
    output logic [2:0]     o_kind,
    output logic [7:0]     o_value,
    output logic [3:0]     o_block_kind,
    output logic [7:0]     o_alternate_number,
    output logic           o_last
);

    // line-break tag bytes, first byte in the top lane
    localparam logic [31:0] BR_TAG = 32'h3c62723e;

    logic            r_valid;
    drdf_pkg::t_kind r_kind;
    logic [7:0]      r_value;
    logic [3:0]      r_block_kind;
    logic [7:0]      r_alt;
    logic            r_last;
    logic [2:0]      r_step;

    logic [2:0]      v_nbytes;
    logic [2:0]      v_total;
    logic            v_load;
    logic            v_is_end;
    drdf_pkg::t_kind v_kind;
    logic [7:0]      v_value;
    logic [7:0]      v_alt;

    // beat selection within the head command
    always_comb begin
        if (i_head.br) begin
            v_nbytes = 3'd4;
        end else if (i_head.item_valid) begin
            v_nbytes = 3'd1;
        end else begin
            v_nbytes = 3'd0;
        end
        v_total  = v_nbytes + {2'd0, i_head.end_valid};
        v_is_end = (r_step >= v_nbytes);
        if (v_is_end) begin
            v_kind  = drdf_pkg::KIND_BLOCK_END;
            v_value = 8'd0;
            v_alt   = 8'd0;
        end else if (i_head.br) begin
            v_kind  = drdf_pkg::KIND_DEFINITION;
            case (r_step[1:0])
                2'd0:    v_value = BR_TAG[31:24];
                2'd1:    v_value = BR_TAG[23:16];
                2'd2:    v_value = BR_TAG[15:8];
                default: v_value = BR_TAG[7:0];
            endcase
            v_alt   = 8'd0;
        end else begin
            v_kind  = i_head.item_kind;
            v_value = i_head.value;
            v_alt   = i_head.alt;
        end
    end

    assign v_load     = i_head_valid && (!r_valid || i_pop);
    assign o_head_pop = v_load && (r_step == v_total - 3'd1);

    // step counter and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= 3'd0;
        end else begin
            if (v_load) begin
                r_valid <= 1'b1;
                r_step  <= o_head_pop ? 3'd0 : r_step + 3'd1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (v_load) begin
            r_kind       <= v_kind;
            r_value      <= v_value;
            r_block_kind <= i_head.block_kind;
            r_alt        <= v_alt;
            r_last       <= (v_kind == drdf_pkg::KIND_BLOCK_END) ||
                            (v_kind == drdf_pkg::KIND_STREAM_END);
        end
    end

    assign o_empty            = !r_valid;
    assign o_kind             = r_kind;
    assign o_value            = r_value;
    assign o_block_kind       = r_block_kind;
    assign o_alternate_number = r_alt;
    assign o_last             = r_last;

`ifndef NO_ASSERTIONS
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_head_valid |-> (r_step < v_total))
        else $error("sequencer step past command");
    a_step_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_head_valid |-> (r_step == 3'd0))
        else $error("sequencer step without command");
`endif

endmodule

/* bench/drdf_deframe_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drdf_deframe_checker
// Watches both queue ports of the deframer. Every byte taken on the input
// side runs through a cycle-free model of the parser, which queues the
// deframed beats it should cause; every beat popped on the result side is
// compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module drdf_deframe_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic       i_full,
    input  logic [7:0] i_data_byte,
    input  logic       i_empty,
    input  logic       i_pop,
    input  logic [2:0] i_kind,
    input  logic [7:0] i_value,
    input  logic [3:0] i_block_kind,
    input  logic [7:0] i_alternate_number,
    input  logic       i_last,
    output int         o_errors,
    output int         o_outstanding
);

    localparam int          LEN_BYTES_MAX = drdf_pkg::MAX_LENGTH_BYTES_DEF;
    localparam logic [31:0] BR_TAG        = "<br>";

    // parser position within a block
    typedef enum logic [3:0] {
        S_HDR,
        S_LEN,
        S_RAW,
        S_HW_LEN,
        S_HW,
        S_DEFLEN_HI,
        S_DEFLEN_LO,
        S_DEF_TEXT,
        S_POS_DIGIT,
        S_DEF_DRAIN,
        S_ALT_LEN,
        S_ALT_TEXT
    } t_parse_state;

    typedef struct packed {
        drdf_pkg::t_kind kind;
        logic [7:0]      value;
        logic [3:0]      blk;
        logic [7:0]      alt;
        logic            is_last;
    } t_deframed;

    t_deframed    deframed_q[$];
    t_parse_state st;
    logic [3:0]   blk_type;
    logic [2:0]   len_left;
    logic [31:0]  payload_cnt;
    logic [15:0]  field_cnt;
    logic [7:0]   alt_ord;
    logic         mark_armed;

    task automatic clear_parser();
        st          = S_HDR;
        blk_type    = 4'h0;
        len_left    = 3'd0;
        payload_cnt = 32'd0;
        field_cnt   = 16'd0;
        alt_ord     = 8'd0;
        mark_armed  = 1'b0;
    endtask

    task automatic add_beat(input drdf_pkg::t_kind k, input logic [7:0] v,
                            input logic [7:0] a, input logic is_last);
        t_deframed beat;
        beat.kind    = k;
        beat.value   = v;
        beat.blk     = blk_type;
        beat.alt     = a;
        beat.is_last = is_last;
        deframed_q.insert(deframed_q.size(), beat);
    endtask

    task automatic drop_field();
        if (field_cnt != 16'd0) field_cnt = field_cnt - 16'd1;
    endtask

    // length known: either close an empty block or enter its payload
    task automatic open_payload();
        if (payload_cnt == 32'd0) begin
            st = S_HDR;
            add_beat(drdf_pkg::KIND_BLOCK_END, 8'h00, 8'h00, 1'b1);
        end else if (blk_type == drdf_pkg::TYPE_ENTRY_A ||
                     blk_type == drdf_pkg::TYPE_ENTRY_B) begin
            st = S_HW_LEN;
        end else begin
            st = S_RAW;
        end
    endtask

    // one definition byte: line-break expansion and part-of-speech marker
    task automatic def_text(input logic [7:0] b);
        logic wide;
        logic pos_mark;
        wide     = (field_cnt >= 16'd3);
        pos_mark = 1'b0;
        if (mark_armed) begin
            mark_armed = 1'b0;
            pos_mark   = (b == drdf_pkg::BYTE_POS);
        end
        if (pos_mark) begin
            drop_field();
            st = S_POS_DIGIT;
        end else begin
            if (b == drdf_pkg::BYTE_LF) begin
                add_beat(drdf_pkg::KIND_DEFINITION, BR_TAG[31:24], 8'h00, 1'b0);
                add_beat(drdf_pkg::KIND_DEFINITION, BR_TAG[23:16], 8'h00, 1'b0);
                add_beat(drdf_pkg::KIND_DEFINITION, BR_TAG[15:8], 8'h00, 1'b0);
                add_beat(drdf_pkg::KIND_DEFINITION, BR_TAG[7:0], 8'h00, 1'b0);
            end else if (b == drdf_pkg::BYTE_MARK) begin
                if (wide) mark_armed = 1'b1;
            end else begin
                add_beat(drdf_pkg::KIND_DEFINITION, b, 8'h00, 1'b0);
            end
            drop_field();
            if (field_cnt == 16'd0) begin
                mark_armed = 1'b0;
                st         = S_ALT_LEN;
            end
        end
    endtask

    // everything one accepted byte causes
    task automatic deframe_byte(input logic [7:0] b);
        if (st == S_HDR) begin
            blk_type    = b[3:0];
            mark_armed  = 1'b0;
            alt_ord     = 8'd0;
            field_cnt   = 16'd0;
            len_left    = 3'd0;
            payload_cnt = 32'd0;
            if (b[3:0] == drdf_pkg::TYPE_STREAM_END) begin
                add_beat(drdf_pkg::KIND_STREAM_END, 8'h00, 8'h00, 1'b1);
            end else if (b[7:4] < 4'd4) begin
                if (b[7:4] + 1 > LEN_BYTES_MAX) begin
                    open_payload();
                end else begin
                    len_left = 3'(b[7:4]) + 3'd1;
                    st       = S_LEN;
                end
            end else begin
                payload_cnt = {28'd0, b[7:4] - 4'd4};
                open_payload();
            end
        end else if (st == S_LEN) begin
            payload_cnt = {payload_cnt[23:0], b};
            if (len_left != 3'd0) len_left = len_left - 3'd1;
            if (len_left == 3'd0) open_payload();
        end else begin
            case (st)
                S_HW_LEN: begin
                    field_cnt = {8'h00, b};
                    st        = (b != 8'h00) ? S_HW : S_DEFLEN_HI;
                end
                S_HW: begin
                    add_beat(drdf_pkg::KIND_HEADWORD, b, 8'h00, 1'b0);
                    drop_field();
                    if (field_cnt == 16'd0) st = S_DEFLEN_HI;
                end
                S_DEFLEN_HI: begin
                    field_cnt = {b, 8'h00};
                    st        = S_DEFLEN_LO;
                end
                S_DEFLEN_LO: begin
                    field_cnt  = field_cnt | {8'h00, b};
                    mark_armed = 1'b0;
                    st         = (field_cnt != 16'd0) ? S_DEF_TEXT : S_ALT_LEN;
                end
                S_DEF_TEXT: begin
                    def_text(b);
                end
                S_POS_DIGIT: begin
                    if (b >= drdf_pkg::BYTE_DIGIT0 &&
                        (b - drdf_pkg::BYTE_DIGIT0) <= drdf_pkg::POS_INDEX_MAX)
                        add_beat(drdf_pkg::KIND_POS_INDEX, b - drdf_pkg::BYTE_DIGIT0,
                                 8'h00, 1'b0);
                    drop_field();
                    st = (field_cnt != 16'd0) ? S_DEF_DRAIN : S_ALT_LEN;
                end
                S_DEF_DRAIN: begin
                    drop_field();
                    if (field_cnt == 16'd0) st = S_ALT_LEN;
                end
                S_ALT_LEN: begin
                    field_cnt = {8'h00, b};
                    if (alt_ord != 8'hff) alt_ord = alt_ord + 8'd1;
                    st = (b != 8'h00) ? S_ALT_TEXT : S_ALT_LEN;
                end
                S_ALT_TEXT: begin
                    add_beat(drdf_pkg::KIND_ALTERNATE, b, alt_ord, 1'b0);
                    drop_field();
                    if (field_cnt == 16'd0) st = S_ALT_LEN;
                end
                default: begin
                    add_beat(drdf_pkg::KIND_OTHER, b, 8'h00, 1'b0);
                end
            endcase
            // payload count closes the block whatever the field state
            if (payload_cnt != 32'd0) payload_cnt = payload_cnt - 32'd1;
            if (payload_cnt == 32'd0) begin
                st         = S_HDR;
                mark_armed = 1'b0;
                add_beat(drdf_pkg::KIND_BLOCK_END, 8'h00, 8'h00, 1'b1);
            end
        end
    endtask

    // compare a popped beat with the oldest prediction
    task automatic check_beat();
        t_deframed want;
        if (deframed_q.size() == 0) begin
            $display("%0t: unexpected result beat kind=%0d value=%h blk=%h alt=%0d last=%b",
                     $time, i_kind, i_value, i_block_kind, i_alternate_number, i_last);
            o_errors++;
        end else begin
            want = deframed_q.pop_front();
            if (i_kind !== want.kind || i_value !== want.value || i_block_kind !== want.blk ||
                i_alternate_number !== want.alt || i_last !== want.is_last) begin
                $display("%0t: mismatch expected kind=%0d value=%h blk=%h alt=%0d last=%b",
                         $time, want.kind, want.value, want.blk, want.alt, want.is_last);
                $display("%0t:          actual   kind=%0d value=%h blk=%h alt=%0d last=%b",
                         $time, i_kind, i_value, i_block_kind, i_alternate_number, i_last);
                o_errors++;
            end
        end
    endtask

    // sample both ports at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parser();
            deframed_q.delete();
            o_errors = 0;
        end else begin
            if (i_push && !i_full) deframe_byte(i_data_byte);
            if (i_pop && !i_empty) check_beat();
        end
        o_outstanding = deframed_q.size();
    end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Byte-stream test of the dictionary record deframer. A short directed
// stream covers the header forms and definition markup, then random
// blocks follow: mostly well-formed entries with random content, plus raw,
// truncated, padded and noise blocks. Both sides idle at random, and the
// receiver holds off once for a long stretch to back up the input.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int RANDOM_ITEMS = 120;
    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 12;
    localparam int IDLE_PCT     = 12;
    localparam int HOLD_AT      = 60;
    localparam int HOLD_CYCLES  = 200;
    localparam int QUIET_FROM   = 260;
    localparam int QUIET_TO     = 420;

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    logic [7:0] i_data_byte;
    logic       empty;
    logic       pop;
    logic [2:0] o_kind;
    logic [7:0] o_value;
    logic [3:0] o_block_kind;
    logic [7:0] o_alternate_number;
    logic       o_last;
    int         chk_errors;
    int         chk_outstanding;
    int         cycle_cnt;

    logic [7:0] stim_q[$];

    dictionary_record_deframer_unit DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .push               (push),
        .full               (full),
        .i_data_byte        (i_data_byte),
        .empty              (empty),
        .pop                (pop),
        .o_kind             (o_kind),
        .o_value            (o_value),
        .o_block_kind       (o_block_kind),
        .o_alternate_number (o_alternate_number),
        .o_last             (o_last)
    );

    drdf_deframe_checker deframe_check (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_push             (push),
        .i_full             (full),
        .i_data_byte        (i_data_byte),
        .i_empty            (empty),
        .i_pop              (pop),
        .i_kind             (o_kind),
        .i_value            (o_value),
        .i_block_kind       (o_block_kind),
        .i_alternate_number (o_alternate_number),
        .i_last             (o_last),
        .o_errors           (chk_errors),
        .o_outstanding      (chk_outstanding)
    );

    // append one byte to the stimulus stream
    task automatic put_byte(input logic [7:0] b);
        stim_q.insert(stim_q.size(), b);
    endtask

    // header with either the short length form or 1..4 length bytes
    task automatic put_header(input logic [3:0] btype, input int unsigned plen);
        int unsigned nlen;
        logic [3:0]  hi_nib;
        if (plen <= 11 && $urandom_range(0, 1) == 1) begin
            hi_nib = 4'(plen + 4);
            put_byte({hi_nib, btype});
        end else begin
            nlen   = (plen > 255) ? $urandom_range(2, 4) : $urandom_range(1, 4);
            hi_nib = 4'(nlen - 1);
            put_byte({hi_nib, btype});
            for (int k = int'(nlen) - 1; k >= 0; k--) put_byte(8'(plen >> (8 * k)));
        end
    endtask

    // entry block: headword, marked-up definition, alternates; sometimes
    // padded past its fields or cut short by the payload count
    task automatic put_entry();
        logic [7:0]  body[$];
        logic [7:0]  dtext[$];
        logic [7:0]  pat;
        logic [3:0]  btype;
        int unsigned n_hw;
        int unsigned n_keep;
        int unsigned pick;
        btype = ($urandom_range(0, 1) == 1) ? drdf_pkg::TYPE_ENTRY_A : drdf_pkg::TYPE_ENTRY_B;
        n_hw  = $urandom_range(0, 4);
        body.insert(body.size(), 8'(n_hw));
        repeat (n_hw) body.insert(body.size(), 8'($urandom));
        repeat ($urandom_range(0, 6)) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                dtext.insert(dtext.size(), 8'($urandom));
            end else if (pick < 60) begin
                dtext.insert(dtext.size(), drdf_pkg::BYTE_LF);
            end else if (pick < 72) begin
                dtext.insert(dtext.size(), drdf_pkg::BYTE_MARK);
            end else begin
                pat = (pick < 92) ? 8'(drdf_pkg::BYTE_DIGIT0 + $urandom_range(0, 10))
                                  : 8'($urandom);
                dtext.insert(dtext.size(), drdf_pkg::BYTE_MARK);
                dtext.insert(dtext.size(), drdf_pkg::BYTE_POS);
                dtext.insert(dtext.size(), pat);
            end
        end
        body.insert(body.size(), ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'h00);
        body.insert(body.size(), 8'(dtext.size()));
        foreach (dtext[k]) body.insert(body.size(), dtext[k]);
        repeat ($urandom_range(0, 3)) begin
            pat = 8'($urandom_range(0, 3));
            body.insert(body.size(), pat);
            repeat (pat) body.insert(body.size(), 8'($urandom));
        end
        pick = $urandom_range(0, 99);
        if (pick < 10) repeat ($urandom_range(1, 3)) body.insert(body.size(), 8'($urandom));
        n_keep = (pick >= 10 && pick < 22) ? $urandom_range(0, body.size() - 1) : body.size();
        put_header(btype, n_keep);
        for (int k = 0; k < n_keep; k++) put_byte(body[k]);
    endtask

    task automatic put_raw();
        logic [3:0]  btype;
        int unsigned n;
        do btype = 4'($urandom);
        while (btype == drdf_pkg::TYPE_STREAM_END || btype == drdf_pkg::TYPE_ENTRY_A ||
               btype == drdf_pkg::TYPE_ENTRY_B);
        n = $urandom_range(0, 8);
        put_header(btype, n);
        repeat (n) put_byte(8'($urandom));
    endtask

    // any header byte, length kept small, random payload
    task automatic put_noise();
        logic [7:0]  hdr;
        int unsigned n;
        hdr = 8'($urandom);
        put_byte(hdr);
        if (hdr[3:0] != drdf_pkg::TYPE_STREAM_END) begin
            if (hdr[7:4] < 4'd4) begin
                repeat (hdr[7:4]) put_byte(8'h00);
                n = $urandom_range(0, 8);
                put_byte(8'(n));
            end else begin
                n = 32'(hdr[7:4]) - 32'd4;
            end
            repeat (n) put_byte(8'($urandom));
        end
    endtask

    task automatic put_stream_end();
        logic [3:0] hi_nib;
        hi_nib = 4'($urandom);
        put_byte({hi_nib, drdf_pkg::TYPE_STREAM_END});
    endtask

    task automatic build_stimulus();
        int unsigned n_directed;
        int unsigned pick;
        // stream end, empty block on the header and on a length byte
        put_byte({4'h0, drdf_pkg::TYPE_STREAM_END});
        put_byte(8'h40);
        put_byte(8'h03);
        put_byte(8'h00);
        // raw block with both byte extremes
        put_byte(8'h62);
        put_byte(8'h00);
        put_byte(8'hff);
        // entry: line feed, unfinished marker, part-of-speech 5 then skipped
        // tail, empty alternate, one-byte alternate
        put_byte({4'h0, drdf_pkg::TYPE_ENTRY_A});
        put_byte(8'd14);
        put_byte(8'h01);
        put_byte(8'h41);
        put_byte(8'h00);
        put_byte(8'h07);
        put_byte(drdf_pkg::BYTE_LF);
        put_byte(drdf_pkg::BYTE_MARK);
        put_byte(8'h41);
        put_byte(drdf_pkg::BYTE_MARK);
        put_byte(drdf_pkg::BYTE_POS);
        put_byte(drdf_pkg::BYTE_DIGIT0 + 8'd5);
        put_byte(8'h58);
        put_byte(8'h00);
        put_byte(8'h01);
        put_byte(8'h7a);
        // entry whose definition ends on a marker too short to count
        put_byte({4'h9, drdf_pkg::TYPE_ENTRY_B});
        put_byte(8'h00);
        put_byte(8'h00);
        put_byte(8'h02);
        put_byte(8'h41);
        put_byte(drdf_pkg::BYTE_MARK);
        n_directed = stim_q.size();

        // random blocks, mostly well-formed entries
        while (stim_q.size() < n_directed + RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) put_stream_end();
            else if (pick < 25) put_raw();
            else if (pick < 85) put_entry();
            else put_noise();
        end
    endtask

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // cycle limit
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("FAILURE");
        $finish;
    end

    // receiver: random pops, one long hold-off, one stretch with no idling
    initial begin
        int rcv_cycle;
        int hold_left;
        pop       = 1'b0;
        rcv_cycle = 0;
        hold_left = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            rcv_cycle++;
            if (rcv_cycle == HOLD_AT) hold_left = HOLD_CYCLES;
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (rcv_cycle >= QUIET_FROM && rcv_cycle < QUIET_TO) begin
                pop <= 1'b1;
            end else begin
                pop <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // sender and verdict
    initial begin
        int idx;
        i_rst_n     = 1'b0;
        push        = 1'b0;
        i_data_byte = 8'h00;
        build_stimulus();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // one beat per byte; a stretch in the random part never idles
        idx = 0;
        while (idx < stim_q.size()) begin
            @(negedge i_clk);
            if (!(idx >= 60 && idx < 140) && $urandom_range(0, 99) < IDLE_PCT) begin
                push <= 1'b0;
            end else begin
                push        <= 1'b1;
                i_data_byte <= stim_q[idx];
                @(posedge i_clk);
                while (full) @(posedge i_clk);
                idx++;
            end
        end
        @(negedge i_clk);
        push <= 1'b0;

        // drain all predicted beats, then keep watching for stray beats
        while (chk_outstanding != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (chk_errors == 0 && chk_outstanding == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
